[hdl/hso_pkg.sv]
`timescale 1ns / 1ps
package hso_pkg;

    localparam int ENTRIES = 8;
    localparam int SLOT_W = $clog2(ENTRIES);

    localparam logic [5:0] PIN_MASK_06 = 6'h03;
    localparam logic [5:0] PIN_MASK_07 = 6'h0C;
    localparam logic [7:0] EVT_T2RST   = 8'h40;
    localparam logic [7:0] EVT_ADC     = 8'h80;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_CLEAR = 2'd1,
        OP_TMR1  = 2'd2,
        OP_TMR2  = 2'd3
    } op_t;

    typedef enum logic [0:0] {
        CFG_EXTENDED = 1'b0,
        CFG_LOCK     = 1'b1
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FIRE,
        ST_DONE
    } back_state_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] entry_time;
        logic [7:0]  entry_command;
        logic [15:0] timer_value;
    } in_item_t;

    typedef struct packed {
        logic [5:0] pin_levels;
        logic       cam_full;
        logic       holding_full;
        logic [3:0] soft_timer_flags_raised;
        logic [7:0] event_flags_raised;
        logic       output_irq;
        logic       soft_timer_irq;
        logic       timer2_reset;
        logic       adc_start;
    } out_item_t;

endpackage

[hdl/hso_front.sv]
`timescale 1ns / 1ps
// Two-deep queue of input items toward the back part.
module hso_front
    import hso_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  in_item_t in_data,
    output logic     q_valid,
    input  logic     q_take,
    output in_item_t q_item
);

    in_item_t   q_mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;
    logic       pop;

    assign in_stall = (cnt_reg == 2'd2);
    assign push = in_valid && !in_stall;
    assign pop = q_take && (cnt_reg != 2'd0);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_item = q_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= in_data;
        end
    end

endmodule

[hdl/hso_back.sv]
`timescale 1ns / 1ps
// Slot store and sequencer: a timer event snapshots its hit mask, then
// fires one slot per cycle in slot order.
module hso_back
    import hso_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      extended_mode,
    input  logic      lock_enable,
    input  logic      q_valid,
    output logic      q_take,
    input  in_item_t  q_item,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);

    logic [ENTRIES-1:0] active_reg, active_next;
    logic [15:0]        time_reg [ENTRIES];
    logic [7:0]         cmd_reg [ENTRIES];
    logic [15:0]        ptime_reg, ptime_next;
    logic [7:0]         pcmd_reg, pcmd_next;
    logic               pvalid_reg, pvalid_next;
    logic [5:0]         pins_reg, pins_next;
    logic [ENTRIES-1:0] hit_reg, hit_next;
    logic [SLOT_W-1:0]  idx_reg, idx_next;
    back_state_t        state_reg, state_next;
    out_item_t          acc_reg, acc_next;
    logic               ov_reg, ov_next;

    logic               wr_en;
    logic [SLOT_W-1:0]  wr_idx;
    logic [15:0]        wr_time;
    logic [7:0]         wr_cmd;
    logic               clr_slots;

    logic [ENTRIES-1:0] free_vec;
    logic [SLOT_W-1:0]  free_idx;
    logic               free_any;
    logic [ENTRIES-1:0] hit_vec;
    logic [7:0]         c;
    logic [3:0]         act;
    logic               locked;
    logic [5:0]         m;
    logic [ENTRIES-1:0] act_after;
    logic [ENTRIES-1:0] free2;
    logic [SLOT_W-1:0]  free2_idx;
    logic               free2_any;

    assign out_valid = ov_reg;
    assign out_data = acc_reg;

    always_comb
    begin
        free_vec = ~active_reg;
        free_any = |free_vec;
        free_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (free_vec[i])
            begin
                free_idx = SLOT_W'(i);
            end
        end
        for (int i = 0; i < ENTRIES; i++)
        begin
            hit_vec[i] = active_reg[i] && (cmd_reg[i][6] == q_item.operation[0])
                         && (time_reg[i] == q_item.timer_value);
        end
    end

    always_comb
    begin
        active_next = active_reg;
        ptime_next = ptime_reg;
        pcmd_next = pcmd_reg;
        pvalid_next = pvalid_reg;
        pins_next = pins_reg;
        hit_next = hit_reg;
        idx_next = idx_reg;
        state_next = state_reg;
        acc_next = acc_reg;
        ov_next = ov_reg && out_stall;
        q_take = 1'b0;
        wr_en = 1'b0;
        wr_idx = free_idx;
        wr_time = q_item.entry_time;
        wr_cmd = q_item.entry_command;
        clr_slots = 1'b0;
        c = cmd_reg[idx_reg];
        act = c[3:0];
        locked = extended_mode && c[7] && lock_enable;
        m = '0;
        act_after = active_reg;
        free2 = '0;
        free2_any = 1'b0;
        free2_idx = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid && !ov_reg)
                begin
                    q_take = 1'b1;
                    acc_next = '0;
                    unique case (op_t'(q_item.operation))
                        OP_LOAD:
                        begin
                            if (free_any)
                            begin
                                wr_en = 1'b1;
                                active_next[free_idx] = 1'b1;
                            end
                            else
                            begin
                                ptime_next = q_item.entry_time;
                                pcmd_next = q_item.entry_command;
                                pvalid_next = 1'b1;
                            end
                            state_next = ST_DONE;
                        end
                        OP_CLEAR:
                        begin
                            active_next = '0;
                            clr_slots = 1'b1;
                            ptime_next = '0;
                            pcmd_next = '0;
                            pvalid_next = 1'b0;
                            state_next = ST_DONE;
                        end
                        default:
                        begin
                            hit_next = hit_vec;
                            idx_next = '0;
                            state_next = ST_FIRE;
                        end
                    endcase
                end
            end
            ST_FIRE:
            begin
                if (hit_reg[idx_reg] && active_reg[idx_reg])
                begin
                    if (act <= 4'd5)
                    begin
                        m = 6'(6'd1 << act[2:0]);
                    end
                    else if (act == 4'd6)
                    begin
                        m = PIN_MASK_06;
                    end
                    else if (act == 4'd7)
                    begin
                        m = PIN_MASK_07;
                    end
                    if (act <= 4'd7)
                    begin
                        pins_next = c[5] ? (pins_reg | m) : (pins_reg & ~m);
                        if (extended_mode)
                        begin
                            acc_next.event_flags_raised = acc_reg.event_flags_raised
                                                          | {2'b00, m};
                        end
                    end
                    else if (act <= 4'd11)
                    begin
                        acc_next.soft_timer_flags_raised[act[1:0]] = 1'b1;
                    end
                    else if (act == 4'd14)
                    begin
                        acc_next.timer2_reset = 1'b1;
                        if (extended_mode)
                        begin
                            acc_next.event_flags_raised = acc_reg.event_flags_raised
                                                          | EVT_T2RST;
                        end
                    end
                    else if (act == 4'd15)
                    begin
                        acc_next.adc_start = 1'b1;
                        if (extended_mode)
                        begin
                            acc_next.event_flags_raised = acc_reg.event_flags_raised
                                                          | EVT_ADC;
                        end
                    end
                    if (c[4])
                    begin
                        if (c[3])
                        begin
                            acc_next.soft_timer_irq = 1'b1;
                        end
                        else
                        begin
                            acc_next.output_irq = 1'b1;
                        end
                    end
                    if (!locked)
                    begin
                        act_after[idx_reg] = 1'b0;
                        free2 = ~act_after;
                        free2_any = |free2;
                        for (int i = ENTRIES - 1; i >= 0; i--)
                        begin
                            if (free2[i])
                            begin
                                free2_idx = SLOT_W'(i);
                            end
                        end
                        active_next = act_after;
                        // refill from the holding register
                        if (pvalid_reg && free2_any)
                        begin
                            wr_en = 1'b1;
                            wr_idx = free2_idx;
                            wr_time = ptime_reg;
                            wr_cmd = pcmd_reg;
                            active_next[free2_idx] = 1'b1;
                            ptime_next = '0;
                            pcmd_next = '0;
                            pvalid_next = 1'b0;
                        end
                    end
                end
                idx_next = idx_reg + 1'b1;
                if (idx_reg == SLOT_W'(ENTRIES - 1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                acc_next.pin_levels = pins_reg;
                acc_next.cam_full = &active_reg;
                acc_next.holding_full = pvalid_reg;
                ov_next = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= '0;
            ptime_reg <= '0;
            pcmd_reg <= '0;
            pvalid_reg <= 1'b0;
            pins_reg <= '0;
            state_reg <= ST_IDLE;
            ov_reg <= 1'b0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                time_reg[i] <= '0;
                cmd_reg[i] <= '0;
            end
        end
        else
        begin
            active_reg <= active_next;
            ptime_reg <= ptime_next;
            pcmd_reg <= pcmd_next;
            pvalid_reg <= pvalid_next;
            pins_reg <= pins_next;
            state_reg <= state_next;
            ov_reg <= ov_next;
            if (clr_slots)
            begin
                for (int i = 0; i < ENTRIES; i++)
                begin
                    time_reg[i] <= '0;
                    cmd_reg[i] <= '0;
                end
            end
            else if (wr_en)
            begin
                time_reg[wr_idx] <= wr_time;
                cmd_reg[wr_idx] <= wr_cmd;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg <= hit_next;
        idx_reg <= idx_next;
        acc_reg <= acc_next;
    end

endmodule

[hdl/hso_compare_cam.sv]
`timescale 1ns / 1ps
// Channel   Handshake        Payload
// in        in_valid/stall   in_item_t
// out       out_valid/stall  out_item_t
// cfg       valid/ready      cfg_index, cfg_data
//
// Load and clear go from idle to done, which registers the result; a timer event
// first runs the fire sequencer (one slot per cycle) between idle and done.
// The back part takes the next item in the cycle after the result transfer.
// rst_n clears slots, holding register, pins and config (extended mode on).
// A two-deep queue lets the input side take up to two items while out stalls.
module hso_compare_cam
    import hso_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic [0:0] cfg_index,
    input  logic      cfg_data
);

    logic     ext_reg;
    logic     lock_reg;
    logic     q_valid;
    logic     q_take;
    in_item_t q_item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ext_reg <= 1'b1;
            lock_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_EXTENDED: ext_reg <= cfg_data;
                CFG_LOCK:     lock_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    hso_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .q_valid  (q_valid),
        .q_take   (q_take),
        .q_item   (q_item)
    );

    hso_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .extended_mode (ext_reg),
        .lock_enable   (lock_reg),
        .q_valid       (q_valid),
        .q_take        (q_take),
        .q_item        (q_item),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_data      (out_data)
    );

`ifndef SYNTHESIS
    a_no_take_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_take |-> q_valid) else $error("take from empty queue");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid) else $error("result dropped");
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> $stable(out_data))
        else $error("stalled result changed");
`endif

endmodule
